### hw/rtl/lmsfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfw_pkg
// shared constants and types of the scrolling frame writer
// ----------------------------------------------------------------------------
package lmsfw_pkg;

    // number of cascaded drivers in the chain (1 or 2)
    localparam int DEVICES      = 1;
    localparam int COLS_PER_DEV = 8;
    localparam int DEPTH        = DEVICES * COLS_PER_DEV;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int COL_W        = $clog2(COLS_PER_DEV);
    localparam int DEV_W        = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 8;

    localparam logic [ADDR_W-1:0] NOOP_ADDR = 4'h0;
    localparam logic [DATA_W-1:0] NOOP_DATA = 8'h00;

    // request from the sequencer to the column store
    typedef struct packed {
        logic              push;
        logic [DATA_W-1:0] push_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
    } store_req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

### hw/rtl/lmsfw_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfw_store
// column store as a circular buffer in a synchronous memory
// ----------------------------------------------------------------------------
module lmsfw_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lmsfw_pkg::store_req_t      req,
    output logic [lmsfw_pkg::DATA_W-1:0] rd_data
);

    logic [lmsfw_pkg::DATA_W-1:0] mem [lmsfw_pkg::DEPTH];
    logic [lmsfw_pkg::DEPTH-1:0]  valid_reg;
    logic [lmsfw_pkg::DEPTH-1:0]  valid_next;
    logic [lmsfw_pkg::IDX_W-1:0]  head_reg;
    logic [lmsfw_pkg::IDX_W-1:0]  head_next;
    logic [lmsfw_pkg::IDX_W-1:0]  rd_phys;
    logic [lmsfw_pkg::DATA_W-1:0] rd_data_reg;
    logic                         rd_valid_reg;

    // head points at the oldest column, logical index 0
    assign rd_phys = req.rd_idx + head_reg;

    always_comb begin
        valid_next = valid_reg;
        head_next  = head_reg;
        if (req.push) begin
            valid_next[head_reg] = 1'b1;
            head_next            = head_reg + lmsfw_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            head_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            head_reg  <= head_next;
        end
    end

    // new column overwrites the oldest one
    always_ff @(posedge aclk) begin
        if (req.push) begin
            mem[head_reg] <= req.push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg  <= mem[rd_phys];
            rd_valid_reg <= valid_reg[rd_phys];
        end
    end

    // never written entries read as the cleared value
    assign rd_data = rd_valid_reg ? rd_data_reg : lmsfw_pkg::NOOP_DATA;

endmodule

### hw/rtl/led_matrix_scroll_frame_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scroll_frame_writer_core
// scrolls a column into the display store and emits the refresh words
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_column_bits                | in
//  result  | m_valid m_ready m_reg_address m_reg_data     | out
//          | m_frame_end m_last                           |
//
// each column transfer yields DEVICES*DEVICES*8 word transfers (8 at one
// device), one issued per cycle from a single read port of the column store
// while the result side does not stall
// the next column is taken in the cycle that issues the final read
// a word passes the registered store read and the read stage, then the
// output register
// aresetn is synchronous; the store reads as all zero after reset through
// per-entry valid bits, no clearing pass
// a stall on m_ready holds the output register, the read stage and the
// sequencer in turn
// ----------------------------------------------------------------------------
module led_matrix_scroll_frame_writer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lmsfw_pkg::DATA_W-1:0]      s_column_bits,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lmsfw_pkg::ADDR_W-1:0]      m_reg_address,
    output logic [lmsfw_pkg::DATA_W-1:0]      m_reg_data,
    output logic                              m_frame_end,
    output logic                              m_last
);

    lmsfw_pkg::state_t state_reg, state_next;

    // word sequencer counters: device, column address, word in frame
    logic [lmsfw_pkg::DEV_W-1:0] dev_reg, dev_next;
    logic [lmsfw_pkg::COL_W-1:0] col_reg, col_next;
    logic [lmsfw_pkg::DEV_W-1:0] wrd_reg, wrd_next;

    // read stage: word info waiting on the memory read data
    logic                          s1_valid_reg, s1_valid_next;
    logic [lmsfw_pkg::ADDR_W-1:0]  s1_addr_reg;
    logic                          s1_noop_reg;
    logic                          s1_fend_reg;
    logic                          s1_last_reg;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [lmsfw_pkg::ADDR_W-1:0]  m_addr_reg;
    logic [lmsfw_pkg::DATA_W-1:0]  m_data_reg;
    logic                          m_fend_reg;
    logic                          m_last_reg;

    logic                          out_free;
    logic                          s1_move;
    logic                          issue;
    logic                          accept;
    logic                          wrd_end;
    logic                          col_end;
    logic                          dev_end;
    logic                          word_final;
    logic                          word_noop;
    logic [lmsfw_pkg::DATA_W-1:0]  rd_data;
    lmsfw_pkg::store_req_t         store_req;

    assign wrd_end    = (wrd_reg == lmsfw_pkg::DEV_W'(lmsfw_pkg::DEVICES - 1));
    assign col_end    = (col_reg == lmsfw_pkg::COL_W'(lmsfw_pkg::COLS_PER_DEV - 1));
    assign dev_end    = (dev_reg == lmsfw_pkg::DEV_W'(lmsfw_pkg::DEVICES - 1));
    assign word_final = wrd_end && col_end && dev_end;
    assign word_noop  = (wrd_reg != dev_reg);

    // handshake and pipeline advance
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign issue    = (state_reg == lmsfw_pkg::ST_RUN) && (!s1_valid_reg || s1_move);
    assign s_ready  = (state_reg == lmsfw_pkg::ST_IDLE) || (issue && word_final);
    assign accept   = s_valid && s_ready;

    // store access: push on the column transfer, one read per issued word
    always_comb begin
        store_req.push      = accept;
        store_req.push_data = s_column_bits;
        store_req.rd_en     = issue;
        store_req.rd_idx    = lmsfw_pkg::IDX_W'(int'(dev_reg) * lmsfw_pkg::COLS_PER_DEV
                                                + int'(col_reg));
    end

    lmsfw_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rd_data (rd_data)
    );

    // sequencer state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lmsfw_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = lmsfw_pkg::ST_RUN;
                end
            end
            lmsfw_pkg::ST_RUN: begin
                if (issue && word_final && !accept) begin
                    state_next = lmsfw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lmsfw_pkg::ST_IDLE;
            end
        endcase
    end

    // counters wrap back to zero after the final word of a refresh
    always_comb begin
        dev_next = dev_reg;
        col_next = col_reg;
        wrd_next = wrd_reg;
        if (issue) begin
            if (wrd_end) begin
                wrd_next = '0;
                if (col_end) begin
                    col_next = '0;
                    dev_next = dev_end ? '0 : dev_reg + lmsfw_pkg::DEV_W'(1);
                end else begin
                    col_next = col_reg + lmsfw_pkg::COL_W'(1);
                end
            end else begin
                wrd_next = wrd_reg + lmsfw_pkg::DEV_W'(1);
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (issue) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lmsfw_pkg::ST_IDLE;
            dev_reg      <= '0;
            col_reg      <= '0;
            wrd_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dev_reg      <= dev_next;
            col_reg      <= col_next;
            wrd_reg      <= wrd_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // word info travels alongside the memory read
    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_addr_reg <= word_noop ? lmsfw_pkg::NOOP_ADDR
                                     : lmsfw_pkg::ADDR_W'(col_reg) + lmsfw_pkg::ADDR_W'(1);
            s1_noop_reg <= word_noop;
            s1_fend_reg <= wrd_end;
            s1_last_reg <= word_final;
        end
    end

    // no-op words carry zero data whatever the read returned
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_addr_reg <= s1_addr_reg;
            m_data_reg <= s1_noop_reg ? lmsfw_pkg::NOOP_DATA : rd_data;
            m_fend_reg <= s1_fend_reg;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reg_address = m_addr_reg;
    assign m_reg_data    = m_data_reg;
    assign m_frame_end   = m_fend_reg;
    assign m_last        = m_last_reg;

endmodule

### hw/rtl/lmsfw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfw_checker
// port-level checks on the frame writer result stream
// ----------------------------------------------------------------------------
module lmsfw_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [lmsfw_pkg::DATA_W-1:0]      s_column_bits,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [lmsfw_pkg::ADDR_W-1:0]      m_reg_address,
    input  logic [lmsfw_pkg::DATA_W-1:0]      m_reg_data,
    input  logic                              m_frame_end,
    input  logic                              m_last
);

    // a waiting column transfer keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_column_bits))
        else $error("column changed while waiting");

    // stalled result holds its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reg_address) && $stable(m_reg_data)
            && $stable(m_frame_end) && $stable(m_last))
        else $error("result word changed while stalled");

    // no-op words carry zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_reg_address == lmsfw_pkg::NOOP_ADDR) |-> m_reg_data == lmsfw_pkg::NOOP_DATA)
        else $error("no-op word with non-zero data");

    // the final word of a refresh also closes its frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_frame_end)
        else $error("refresh ended inside a frame");

    // only no-op and column digit addresses
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_reg_address <= lmsfw_pkg::ADDR_W'(lmsfw_pkg::COLS_PER_DEV))
        else $error("register address out of range");

endmodule

bind led_matrix_scroll_frame_writer_core lmsfw_checker u_lmsfw_checker (.*);
